>>> rtl/stbs_pkg.sv
// ----------------------------------------------------------------------------
// stbs_pkg - shared types and constants for the sorted table search block
// Field widths, stream bit positions, action codes and the result record.
// ----------------------------------------------------------------------------
package stbs_pkg;

    // field widths
    localparam int INDEX_W     = 10;
    localparam int FIELD_KEY_W = 16;
    localparam int COUNT_W     = 11;
    localparam int POS_W       = 10;

    // input tdata layout, lowest bit first
    localparam int IDX_LSB    = 0;
    localparam int VALUE_LSB  = IDX_LSB + INDEX_W;
    localparam int SKEY_LSB   = VALUE_LSB + FIELD_KEY_W;
    localparam int IN_DATA_W  = ((SKEY_LSB + FIELD_KEY_W + 7) / 8) * 8;

    // output tdata: position only, padded to whole bytes
    localparam int OUT_DATA_W = ((POS_W + 7) / 8) * 8;

    typedef enum logic {
        ACT_WRITE  = 1'b0,
        ACT_SEARCH = 1'b1
    } action_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } result_t;

endpackage

>>> rtl/sorted_table_binary_search.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search - binary search over a table of signed keys
// Write beats load the table, search beats return found flag and position.
// ----------------------------------------------------------------------------
// Write beat: no result; a write may follow every cycle while the sequencer is idle.
// Search beat: P probes, P = 0 for an empty table, else at most
//   floor(log2(count)) + 1 (11 for 1024 entries). The next beat can be taken
//   in the same cycle that the core hands the result to the output register.
// One probe a cycle, bound by the single table port and its registered read.
// Reset (aresetn low, synchronous): sequencer idle, output empty, entry_count
//   0. The table is not cleared; entries read as written.
module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_WIDTH   = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration: entry_count
    input  logic                                 cfg_we,
    input  logic [stbs_pkg::COUNT_W-1:0]         cfg_wdata,
    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [9:0] entry_index, [25:10] entry_value, [41:26] search_key, rest zero
    input  logic [stbs_pkg::IN_DATA_W-1:0]       s_tdata,
    // [0] action (0 write, 1 search)
    input  logic                                 s_tuser,
    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [9:0] position, rest zero
    output logic [stbs_pkg::OUT_DATA_W-1:0]      m_tdata,
    // [0] found
    output logic                                 m_tuser
);

    logic [stbs_pkg::COUNT_W-1:0]      entry_count_reg;

    logic [stbs_pkg::INDEX_W-1:0]      in_index;
    logic [stbs_pkg::FIELD_KEY_W-1:0]  in_value;
    logic [stbs_pkg::FIELD_KEY_W-1:0]  in_skey;
    stbs_pkg::action_t                 in_action;
    logic signed [63:0]                value_ext;
    logic signed [63:0]                skey_ext;
    logic [KEY_WIDTH-1:0]              req_key;

    logic                              core_res_valid;
    logic                              core_res_ready;
    stbs_pkg::result_t                 core_res;

    logic                              m_tvalid_reg;
    stbs_pkg::result_t                 out_res_reg;

    // unpack the beat
    assign in_index  = s_tdata[stbs_pkg::IDX_LSB +: stbs_pkg::INDEX_W];
    assign in_value  = s_tdata[stbs_pkg::VALUE_LSB +: stbs_pkg::FIELD_KEY_W];
    assign in_skey   = s_tdata[stbs_pkg::SKEY_LSB +: stbs_pkg::FIELD_KEY_W];
    assign in_action = stbs_pkg::action_t'(s_tuser);

    // 16-bit two's complement to table key width: sign extend, or keep low bits
    assign value_ext = 64'(signed'(in_value));
    assign skey_ext  = 64'(signed'(in_skey));
    assign req_key   = (in_action == stbs_pkg::ACT_WRITE) ? value_ext[KEY_WIDTH-1:0]
                                                          : skey_ext[KEY_WIDTH-1:0];

    // entry_count register; to be written only while idle, not enforced by the block
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
        end else if (cfg_we) begin
            entry_count_reg <= cfg_wdata;
        end
    end

    stbs_core #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .entry_count (entry_count_reg),
        .req_valid   (s_tvalid),
        .req_ready   (s_tready),
        .req_action  (in_action),
        .req_index   (in_index),
        .req_key     (req_key),
        .res_valid   (core_res_valid),
        .res_ready   (core_res_ready),
        .res         (core_res)
    );

    // output register: the core hands over a result and may take the next beat
    // while this one waits on m_tready
    assign core_res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (core_res_valid && core_res_ready) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (core_res_valid && core_res_ready) begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = stbs_pkg::OUT_DATA_W'(out_res_reg.position);
    assign m_tuser  = out_res_reg.found;

    // a drained output beat with nothing behind it leaves the register empty
    a_out_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !core_res_valid |=> !m_tvalid)
        else $error("output beat repeated after hand-off");

endmodule

>>> rtl/stbs_core.sv
// ----------------------------------------------------------------------------
// stbs_core - key table memory and binary search sequencer
// One synchronous single-port table; one probe (read + compare) per cycle.
// ----------------------------------------------------------------------------
module stbs_core #(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_WIDTH   = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [stbs_pkg::COUNT_W-1:0]      entry_count,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  stbs_pkg::action_t                 req_action,
    input  logic [stbs_pkg::INDEX_W-1:0]      req_index,
    input  logic [KEY_WIDTH-1:0]              req_key,
    output logic                              res_valid,
    input  logic                              res_ready,
    output stbs_pkg::result_t                 res
);

    localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = AW + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [AW-1:0]          low_reg, low_next;
    logic [AW-1:0]          high_reg, high_next;
    logic [AW-1:0]          mid_reg, mid_next;
    logic [KEY_WIDTH-1:0]   key_reg, key_next;
    stbs_pkg::result_t      res_reg, res_next;

    logic [KEY_WIDTH-1:0]   key_mem [TABLE_DEPTH];
    logic [KEY_WIDTH-1:0]   rd_data_reg;
    logic                   mem_we;
    logic [AW-1:0]          mem_addr;

    logic                   clamp;
    logic [CNT_W-1:0]       cnt_eff;
    logic [AW-1:0]          high0;
    logic [AW-1:0]          mid0;
    logic [CNT_W-1:0]       sum_lo;
    logic [CNT_W-1:0]       sum_hi;
    logic [AW-1:0]          mid_lo;
    logic [AW-1:0]          mid_hi;
    logic                   lower_open;
    logic                   upper_open;
    logic                   probe_hit;
    logic                   key_below;
    logic                   index_ok;

    // count clamp and first probe
    assign clamp   = 32'(entry_count) > 32'(TABLE_DEPTH);
    assign cnt_eff = clamp ? CNT_W'(TABLE_DEPTH) : CNT_W'(entry_count);
    assign high0   = AW'(cnt_eff - CNT_W'(1));
    assign mid0    = high0 >> 1;
    assign index_ok = 32'(req_index) < 32'(TABLE_DEPTH);

    // both candidate next probes are formed from registers, ahead of the compare
    assign sum_lo     = CNT_W'(low_reg) + CNT_W'(mid_reg) - CNT_W'(1);
    assign sum_hi     = CNT_W'(mid_reg) + CNT_W'(high_reg) + CNT_W'(1);
    assign mid_lo     = sum_lo[AW:1];
    assign mid_hi     = sum_hi[AW:1];
    assign lower_open = mid_reg > low_reg;
    assign upper_open = mid_reg < high_reg;

    assign probe_hit = rd_data_reg == key_reg;
    assign key_below = $signed(key_reg) < $signed(rd_data_reg);

    assign req_ready = (state_reg == ST_IDLE) || ((state_reg == ST_DONE) && res_ready);
    assign res_valid = state_reg == ST_DONE;
    assign res       = res_reg;

    always_comb begin
        state_next = state_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        mid_next   = mid_reg;
        key_next   = key_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_addr   = mid_reg;

        case (state_reg)
            ST_PROBE: begin
                if (probe_hit) begin
                    state_next        = ST_DONE;
                    res_next.found    = 1'b1;
                    res_next.position = stbs_pkg::POS_W'(mid_reg);
                end else if (key_below && lower_open) begin
                    high_next = mid_reg - AW'(1);
                    mid_next  = mid_lo;
                    mem_addr  = mid_lo;
                end else if (!key_below && upper_open) begin
                    low_next  = mid_reg + AW'(1);
                    mid_next  = mid_hi;
                    mem_addr  = mid_hi;
                end else begin
                    state_next = ST_DONE;
                    res_next   = '0;
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (req_valid && req_ready) begin
            if (req_action == stbs_pkg::ACT_WRITE) begin
                mem_we     = index_ok;
                mem_addr   = AW'(req_index);
                state_next = ST_IDLE;
            end else begin
                key_next = req_key;
                if (cnt_eff == '0) begin
                    state_next = ST_DONE;
                    res_next   = '0;
                end else begin
                    low_next   = '0;
                    high_next  = high0;
                    mid_next   = mid0;
                    mem_addr   = mid0;
                    state_next = ST_PROBE;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        low_reg  <= low_next;
        high_reg <= high_next;
        mid_reg  <= mid_next;
        key_reg  <= key_next;
        res_reg  <= res_next;
    end

    // table: single port, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            key_mem[mem_addr] <= req_key;
        end
        rd_data_reg <= key_mem[mem_addr];
    end

    // probe always lies inside the live window
    a_probe_window: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_PROBE |-> (low_reg <= mid_reg) && (mid_reg <= high_reg))
        else $error("probe outside search window");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && !res.found |-> res.position == '0)
        else $error("miss result with non-zero position");

    a_empty_table: assert property (@(posedge aclk) disable iff (!aresetn)
        req_valid && req_ready && req_action == stbs_pkg::ACT_SEARCH && cnt_eff == '0
        |=> res_valid && !res.found)
        else $error("empty table search did not miss at once");

endmodule

>>> tb/stbs_search_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stbs_search_checker - scoreboard for the sorted table search block
// Mirrors the key table and entry count from the input side, predicts the
// result of each search beat and compares result beats in order.
// ----------------------------------------------------------------------------
module stbs_search_checker
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [COUNT_W-1:0]    cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  m_tuser,
    output int                    outstanding,
    output int                    fail_count,
    output int                    hit_count
);

    logic signed [FIELD_KEY_W-1:0] key_mirror [TABLE_DEPTH];
    logic [COUNT_W-1:0]            count_mirror;
    result_t                       awaited_results [$];
    int                            mismatches;
    int                            hits_seen;

    // probe sequence: mid rounded down, halve until hit or empty range
    function automatic result_t search_table(logic signed [FIELD_KEY_W-1:0] key);
        result_t res;
        int      lo;
        int      hi;
        int      mid;
        int      span;
        res  = '0;
        span = (count_mirror > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_mirror);
        lo   = 0;
        hi   = span - 1;
        while (lo <= hi && !res.found) begin
            mid = (lo + hi) / 2;
            if (key < key_mirror[mid]) begin
                hi = mid - 1;
            end else if (key > key_mirror[mid]) begin
                lo = mid + 1;
            end else begin
                res.found    = 1'b1;
                res.position = mid[POS_W-1:0];
            end
        end
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        result_t          want;
        logic [POS_W-1:0] got_pos;
        if (!aresetn) begin
            count_mirror = '0;
            awaited_results.delete();
        end else begin
            // result side first, so a stray beat never takes a fresh prediction
            if (m_tvalid && m_tready) begin
                got_pos = m_tdata[POS_W-1:0];
                if (awaited_results.size() == 0) begin
                    $error("result beat with nothing awaited: found %0b position %0d",
                           m_tuser, got_pos);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    if (m_tuser !== want.found) begin
                        $error("found: expected %0b, got %0b", want.found, m_tuser);
                        mismatches++;
                    end
                    if (got_pos !== want.position) begin
                        $error("position: expected %0d, got %0d", want.position, got_pos);
                        mismatches++;
                    end
                    if (m_tdata[OUT_DATA_W-1:POS_W] !== '0) begin
                        $error("tdata padding: expected 0, got %0h",
                               m_tdata[OUT_DATA_W-1:POS_W]);
                        mismatches++;
                    end
                    if (want.found) hits_seen++;
                end
            end
            if (cfg_we) count_mirror = cfg_wdata;
            if (s_tvalid && s_tready) begin
                if (s_tuser == ACT_WRITE) begin
                    key_mirror[s_tdata[IDX_LSB +: INDEX_W]] = s_tdata[VALUE_LSB +: FIELD_KEY_W];
                end else begin
                    awaited_results.push_back(search_table(s_tdata[SKEY_LSB +: FIELD_KEY_W]));
                end
            end
        end
        outstanding <= awaited_results.size();
        fail_count  <= mismatches;
        hit_count   <= hits_seen;
    end

endmodule

>>> tb/sorted_table_binary_search_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_table_binary_search_test - stimulus and verdict for the search block
// Loads key tables of many sizes (empty up to the full 1024 entries), sorted,
// with duplicates and jumbled, then searches them for present, neighbouring
// and random keys while both stream sides idle at random. A separate
// scoreboard predicts every search result and counts mismatches.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_test;
    import stbs_pkg::*;

    localparam int TABLE_DEPTH   = 1024;
    localparam int RANDOM_BEATS  = 1250;  // beats in the random part
    localparam int CALM_BEATS    = 120;   // closing stretch with no idling
    localparam int SETTLE_CYCLES = 16;    // outlasts the longest search
    localparam int LONG_STALL    = 300;   // one long output hold-off

    // block inputs, all known from time zero
    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [COUNT_W-1:0]    cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tready  = 1'b0;
    // block outputs
    logic                  s_tready;
    logic                  m_tvalid;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;

    // scoreboard status
    int outstanding;
    int fail_count;
    int hit_count;

    // stimulus-side copy of the table, only used to aim search keys
    logic signed [FIELD_KEY_W-1:0] shadow_keys [TABLE_DEPTH];

    int beats_sent;
    int writes_sent;
    int searches_sent;
    int sizes_tried;
    int widest;
    int calm_from = 2147483647;
    int send_idle_pct;      // sender idle chance per beat, percent
    int recv_idle_pct;      // receiver idle chance per cycle, percent
    bit calm;               // closing stretch: no idling on either side
    bit hold_req;           // asks the receiver for its one long hold-off

    sorted_table_binary_search #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (FIELD_KEY_W)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    stbs_search_checker #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) search_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .outstanding (outstanding),
        .fail_count  (fail_count),
        .hit_count   (hit_count)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin : watchdog
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Result side: short random hold-offs, plus one long one on request so
    // that the block backs up and drops s_tready while beats keep coming.
    initial begin : sink
        bit held;
        held = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (hold_req && !held) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_STALL) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (!calm && $urandom_range(0, 99) < recv_idle_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic logic signed [FIELD_KEY_W-1:0] any_key();
        return FIELD_KEY_W'($urandom_range(0, 65535));
    endfunction

    // Mostly keys already in the live part of the table, some neighbours
    // (which usually miss, and wrap at the extremes) and some anywhere.
    function automatic logic signed [FIELD_KEY_W-1:0] aim_key(int n);
        logic signed [FIELD_KEY_W-1:0] k;
        int                            roll;
        roll = $urandom_range(0, 9);
        if (n == 0 || roll >= 8) return any_key();
        k = shadow_keys[$urandom_range(0, n - 1)];
        if (roll == 6) k = k + 16'sd1;
        else if (roll == 7) k = k - 16'sd1;
        return k;
    endfunction

    // Offer one beat and hold it until taken. valid stays high if the next
    // beat follows at once; otherwise valid drops for a random idle burst.
    task automatic push_beat(action_t act, logic [INDEX_W-1:0] idx,
                             logic signed [FIELD_KEY_W-1:0] value,
                             logic signed [FIELD_KEY_W-1:0] key);
        logic [IN_DATA_W-1:0] word;
        word = '0;
        word[IDX_LSB +: INDEX_W]       = idx;
        word[VALUE_LSB +: FIELD_KEY_W] = value;
        word[SKEY_LSB +: FIELD_KEY_W]  = key;
        s_tdata  <= word;
        s_tuser  <= act;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (act == ACT_WRITE) begin
            shadow_keys[idx] = value;
            writes_sent++;
        end else begin
            searches_sent++;
        end
        beats_sent++;
        if (beats_sent >= calm_from) calm <= 1'b1;
        if (beats_sent < calm_from && $urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
    endtask

    // Stop sending, wait for every awaited result, then let a trailing
    // write or search finish inside the block.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // entry_count is only changed with the block idle
    task automatic load_count(logic [COUNT_W-1:0] n);
        settle();
        cfg_wdata <= n;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sizes_tried++;
        if (n > widest) widest = n;
    endtask

    // One table setting: set the count, optionally refill entries 0..n-1
    // (ascending with random steps, step 0 giving duplicates, or jumbled),
    // then a run of searches with the odd stray write mixed in.
    task automatic run_phase(int n, bit refill, bit jumbled, bit squeeze);
        int v;
        int step_max;
        int searches;
        load_count(COUNT_W'(n));
        case ($urandom_range(0, 2))
            0:       send_idle_pct = 0;
            1:       send_idle_pct = 10;
            default: send_idle_pct = 35;
        endcase
        case ($urandom_range(0, 2))
            0:       recv_idle_pct <= 0;
            1:       recv_idle_pct <= 15;
            default: recv_idle_pct <= 40;
        endcase
        if (refill) begin
            v        = -32768 + int'($urandom_range(0, 200));
            step_max = (n > 0 && $urandom_range(0, 1) == 1) ? 65535 / n + 1 : 3;
            for (int i = 0; i < n; i++) begin
                if (jumbled) v = int'($urandom_range(0, 65535)) - 32768;
                else if (i > 0) v = v + int'($urandom_range(0, step_max));
                if (v > 32767) v = 32767;
                push_beat(ACT_WRITE, i[INDEX_W-1:0], v[FIELD_KEY_W-1:0], any_key());
            end
        end
        if (n > 64) searches = $urandom_range(20, 40);
        else searches = $urandom_range(3, (2 * n + 4 > 40) ? 40 : 2 * n + 4);
        if (squeeze) hold_req <= 1'b1;
        repeat (searches) begin
            // a stray write may land inside the live range and unsort it
            if ($urandom_range(0, 11) == 0) begin
                push_beat(ACT_WRITE, INDEX_W'($urandom_range(0, TABLE_DEPTH - 1)),
                          any_key(), any_key());
            end else begin
                push_beat(ACT_SEARCH, INDEX_W'($urandom_range(0, TABLE_DEPTH - 1)),
                          any_key(), aim_key(n));
            end
        end
    endtask

    initial begin : stimulus
        int target;
        int n;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // -- directed part --------------------------------------------------
        // empty table straight after reset: always a miss at position 0
        push_beat(ACT_SEARCH, 10'h3FF, 16'sh7FFF, 16'sh0000);
        push_beat(ACT_SEARCH, 10'h000, 16'sh8000, 16'sh8000);
        // extremes, with a duplicated -1 in the middle, and the top index
        push_beat(ACT_WRITE, 10'd0, 16'sh8000, 16'sh7FFF);
        push_beat(ACT_WRITE, 10'd1, 16'shFFFF, 16'sh0000);
        push_beat(ACT_WRITE, 10'd2, 16'shFFFF, 16'shFFFF);
        push_beat(ACT_WRITE, 10'd3, 16'sh0000, 16'sh8000);
        push_beat(ACT_WRITE, 10'd4, 16'sh7FFF, 16'sh0000);
        push_beat(ACT_WRITE, 10'h3FF, 16'sd12345, 16'sh0000);
        load_count(5);
        push_beat(ACT_SEARCH, 10'd0, 16'sh0000, 16'sh8000);  // lowest key
        push_beat(ACT_SEARCH, 10'd0, 16'sh0000, 16'shFFFF);  // duplicate, mid probe
        push_beat(ACT_SEARCH, 10'd0, 16'sh0000, 16'sh0000);
        push_beat(ACT_SEARCH, 10'd0, 16'sh0000, 16'sh7FFF);  // highest key
        push_beat(ACT_SEARCH, 10'd0, 16'sh0000, 16'sh0001);  // gap, miss
        push_beat(ACT_SEARCH, 10'd0, 16'sh0000, 16'sh8001);
        push_beat(ACT_SEARCH, 10'd0, 16'sh0000, 16'sh7FFE);
        // single entry
        load_count(1);
        push_beat(ACT_SEARCH, 10'd0, 16'sh0000, 16'sh8000);
        push_beat(ACT_SEARCH, 10'd0, 16'sh0000, 16'sd5);
        // count written back to zero: empty again
        load_count(0);
        push_beat(ACT_SEARCH, 10'd0, 16'sh0000, 16'sh8000);

        // -- random part ----------------------------------------------------
        target    = beats_sent + RANDOM_BEATS;
        calm_from = target - CALM_BEATS;
        // full table first, sorted, with the long output hold-off
        run_phase(TABLE_DEPTH, 1'b1, 1'b0, 1'b1);
        while (beats_sent < target) begin
            case ($urandom_range(0, 19))
                0:       n = 0;
                1:       n = 1;
                2:       n = 2;
                3:       n = TABLE_DEPTH;
                4:       n = TABLE_DEPTH - 1;
                5:       n = TABLE_DEPTH / 2;
                default: n = $urandom_range(3, 40);
            endcase
            // large sizes search what the full fill left, touched up since
            run_phase(n, n <= 40, $urandom_range(0, 7) == 0, 1'b0);
        end
        settle();

        $display("covered %0d table writes, %0d searches (%0d hits), %0d count settings up to %0d",
                 writes_sent, searches_sent, hit_count, sizes_tried, widest);
        $display("with a %0d-cycle output hold-off and random idle bursts on both sides",
                 LONG_STALL);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
